// File: rtl/bac_pkg.sv
// Package: shared types, constants and command structs for the bounce and contact block.
`default_nettype none
package bac_pkg;
    localparam int BODY_COUNT = 8;
    localparam int POS_FRAC_BITS = 16;
    localparam int IDX_W = 3;
    localparam int PAIR_COUNT = 28;
    localparam int PAIR_W = 5;
    localparam logic [16:0] ONE_FX = 17'h10000;
    localparam logic [15:0] HALF_FX = 16'h8000;
    localparam logic [15:0] VEL_MAX = 16'h7fff;

    localparam logic [0:0] FUNC_WRITE = 1'b0;
    localparam logic [0:0] FUNC_STEP = 1'b1;
    localparam logic [0:0] CFG_COOLDOWN = 1'b0;
    localparam logic [0:0] CFG_ACTIVE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [2:0]  body_index;
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic [15:0] radius;
        logic        dragged;
    } t_in_item;

    typedef struct packed {
        logic       has_contact;
        logic [2:0] first_body;
        logic [2:0] second_body;
        logic       last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECAY, ST_MOVE, ST_PAIR, ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       write_body;
        logic       decay;
        logic       move_en;
        logic       pair_en;
        logic [2:0] body;
        logic [2:0] bi;
        logic [2:0] bj;
        logic [4:0] pair;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic fire;
    } t_status;
endpackage
`default_nettype wire

// File: rtl/bac_ctrl.sv
// Controller: sequences decay, body moves, pair tests and result beats.
`default_nettype none
module bac_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [3:0]       i_active,
    input  wire bac_pkg::t_status i_status,
    input  wire logic             i_out_ready,
    output bac_pkg::t_cmd         o_cmd,
    output logic                  o_busy,
    output logic                  o_out_valid,
    output bac_pkg::t_out_item    o_out
);
    bac_pkg::t_state r_state, n_state;
    logic [2:0] r_i, n_i, r_j, n_j;
    logic [4:0] r_k, n_k;
    logic       r_any, n_any;
    logic [3:0] n_cnt;
    logic       last_pair;
    logic       can_emit, go;
    bac_pkg::t_out_item r_pend, n_pend;
    logic       r_ov, n_ov;
    bac_pkg::t_out_item r_out, n_out;

    assign n_cnt = (i_active > 4'd8) ? 4'd8 : i_active;
    assign last_pair = (r_i == 3'd6);
    assign can_emit = !r_ov || i_out_ready;
    // hold the pair walk while a held contact cannot leave
    assign go = !r_any || can_emit;

    always_comb begin
        n_state = r_state;
        n_i = r_i; n_j = r_j; n_k = r_k; n_any = r_any;
        n_pend = r_pend;
        n_ov = r_ov; n_out = r_out;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            bac_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = bac_pkg::ST_DECAY;
                end
            end
            bac_pkg::ST_DECAY: begin
                n_i = '0; n_state = bac_pkg::ST_MOVE;
            end
            bac_pkg::ST_MOVE: begin
                if ({1'b0, r_i} + 4'd1 >= n_cnt || r_i == 3'd7) begin
                    n_i = 3'd0; n_j = 3'd1; n_k = '0; n_any = 1'b0;
                    n_state = bac_pkg::ST_PAIR;
                end else begin
                    n_i = r_i + 3'd1;
                end
            end
            bac_pkg::ST_PAIR: begin
                if (go) begin
                    // a new contact releases the held one as a non-final beat
                    if (i_status.fire) begin
                        if (r_any) begin
                            n_out = r_pend; n_ov = 1'b1;
                        end
                        n_pend = '{1'b1, r_i, r_j, 1'b0};
                        n_any = 1'b1;
                    end
                    if (r_j == 3'd7) begin
                        n_i = r_i + 3'd1; n_j = r_i + 3'd2;
                    end else begin
                        n_j = r_j + 3'd1;
                    end
                    n_k = r_k + 5'd1;
                    if (last_pair) begin
                        n_state = bac_pkg::ST_DONE;
                    end
                end
            end
            bac_pkg::ST_DONE: begin
                if (can_emit) begin
                    if (r_any) begin
                        n_out = r_pend; n_out.last = 1'b1;
                    end else begin
                        n_out = '{1'b0, 3'd0, 3'd0, 1'b1};
                    end
                    n_ov = 1'b1;
                    n_state = bac_pkg::ST_IDLE;
                end
            end
            default: n_state = bac_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bac_pkg::ST_IDLE;
            r_ov <= 1'b0;
            r_any <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov <= n_ov;
            r_any <= n_any;
        end
        r_i <= n_i; r_j <= n_j; r_k <= n_k;
        r_pend <= n_pend;
        r_out <= n_out;
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.write_body = 1'b0;
        o_cmd.decay = (r_state == bac_pkg::ST_DECAY);
        o_cmd.move_en = (r_state == bac_pkg::ST_MOVE) && (n_cnt != 4'd0);
        o_cmd.pair_en = (r_state == bac_pkg::ST_PAIR) && ({1'b0, r_j} < n_cnt) && go;
        o_cmd.body = r_i;
        o_cmd.bi = r_i;
        o_cmd.bj = r_j;
        o_cmd.pair = r_k;
    end

    assign o_busy = (r_state != bac_pkg::ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out = r_out;
endmodule
`default_nettype wire

// File: rtl/bac_dp.sv
// Datapath: body table, wall reflection, pair touch test and pair cooldown state.
`default_nettype none
module bac_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire bac_pkg::t_in_item i_item,
    input  wire logic [15:0]      i_cooldown,
    input  wire bac_pkg::t_cmd    i_cmd,
    output bac_pkg::t_status      o_status
);
    logic [16:0] r_px [8];
    logic [16:0] r_py [8];
    logic signed [15:0] r_vx [8];
    logic signed [15:0] r_vy [8];
    logic [15:0] r_rad [8];
    logic [7:0]  r_held;
    logic [27:0] r_touch;
    logic [15:0] r_cd [28];

    function automatic logic [15:0] mag_sat(input logic signed [15:0] v);
        logic [15:0] m;
        m = v[15] ? 16'(-v) : 16'(v);
        return (m > bac_pkg::VEL_MAX) ? bac_pkg::VEL_MAX : m;
    endfunction

    // wall reflection for one axis: two passes then clamp
    function automatic logic [33:0] move_axis(input logic [16:0] pos,
                                              input logic signed [15:0] vel,
                                              input logic [15:0] lo16);
        logic signed [19:0] p, lo, hi;
        logic signed [15:0] v;
        integer pass;
        lo = 20'(lo16);
        hi = 20'(bac_pkg::ONE_FX) - lo;
        p = 20'(pos) + 20'(vel);
        v = vel;
        for (pass = 0; pass < 2; pass++) begin
            if (p < lo) begin
                p = (lo <<< 1) - p; v = mag_sat(v);
            end else if (p > hi) begin
                p = (hi <<< 1) - p; v = -mag_sat(v);
            end
        end
        if (p < lo) p = lo;
        if (p > hi) p = hi;
        return {p[16:0], 1'b0, v};
    endfunction

    logic [2:0] b, bi, bj;
    logic [33:0] mx, my;
    logic signed [17:0] dx, dy;
    logic [16:0] adx, ady;
    logic [33:0] dx2, dy2;
    logic [16:0] rs;
    logic [33:0] rs2;
    logic touch;

    assign b = i_cmd.body;
    assign bi = i_cmd.bi;
    assign bj = i_cmd.bj;
    assign mx = move_axis(r_px[b], r_vx[b], r_rad[b]);
    assign my = move_axis(r_py[b], r_vy[b], r_rad[b]);
    assign dx = 18'(r_px[bi]) - 18'(r_px[bj]);
    assign dy = 18'(r_py[bi]) - 18'(r_py[bj]);
    // square the magnitudes at full width
    assign adx = dx[17] ? 17'(-dx) : 17'(dx);
    assign ady = dy[17] ? 17'(-dy) : 17'(dy);
    assign dx2 = {17'd0, adx} * {17'd0, adx};
    assign dy2 = {17'd0, ady} * {17'd0, ady};
    assign rs = 17'(r_rad[bi]) + 17'(r_rad[bj]);
    assign rs2 = {17'd0, rs} * {17'd0, rs};
    assign touch = ({1'b0, dx2} + {1'b0, dy2}) <= {1'b0, rs2};

    assign o_status.fire = i_cmd.pair_en && touch && !r_touch[i_cmd.pair]
                           && (r_cd[i_cmd.pair] == 16'd0);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_px[i_item.body_index] <= i_item.pos_x;
            r_py[i_item.body_index] <= i_item.pos_y;
            r_vx[i_item.body_index] <= i_item.vel_x;
            r_vy[i_item.body_index] <= i_item.vel_y;
            r_rad[i_item.body_index] <= (i_item.radius > bac_pkg::HALF_FX) ?
                                        bac_pkg::HALF_FX : i_item.radius;
            r_held[i_item.body_index] <= i_item.dragged;
        end else if (i_cmd.move_en && !r_held[b]) begin
            r_px[b] <= mx[33:17];
            r_vx[b] <= mx[15:0];
            r_py[b] <= my[33:17];
            r_vy[b] <= my[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch <= '0;
            for (int k = 0; k < 28; k++) r_cd[k] <= '0;
        end else if (i_cmd.decay) begin
            for (int k = 0; k < 28; k++)
                if (r_cd[k] != 16'd0) r_cd[k] <= r_cd[k] - 16'd1;
        end else if (i_cmd.pair_en) begin
            if (!touch) begin
                r_touch[i_cmd.pair] <= 1'b0;
            end else if (!r_touch[i_cmd.pair]) begin
                r_touch[i_cmd.pair] <= 1'b1;
                if (r_cd[i_cmd.pair] == 16'd0) r_cd[i_cmd.pair] <= i_cooldown;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/bounce_and_contact_step.sv
// Top level: bounce and contact step block with body table and contact events.
//
// Input channel (i_in_valid/o_in_ready, payload i_in) carries two kinds of
// beat. A write beat loads one body entry and gives no result. A step beat
// decays all pair cooldowns, moves the active bodies that are not dragged
// one per cycle, walks the 28 pairs one per cycle, holding while a stalled
// output blocks a held contact, and tests the pairs of active bodies, then
// loads the final beat. A found contact is held until the next one is found
// or the walk ends, which decides last; a step with no contact yields one
// beat with has_contact clear and last set. o_in_ready returns once the
// final beat is taken.
// Only one step is in flight; o_in_ready is low while a step runs or a beat waits.
// When the receiver stalls, the pair walk holds on its current pair while a
// held contact cannot leave the output register.
// Configuration beats (i_cfg_valid/o_cfg_ready) write cooldown_steps (index
// 0) or active_bodies (index 1); write them only while idle.
// Reset (i_rst_n low, synchronous) clears pair state, cooldown_steps to 0,
// active_bodies to 8. Body entries are undefined until written.
`default_nettype none
module bounce_and_contact_step (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire bac_pkg::t_in_item i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output bac_pkg::t_out_item     o_out,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_data
);
    logic [15:0] r_cooldown;
    logic [3:0]  r_active;
    logic        busy, acc;
    bac_pkg::t_cmd cmd;
    bac_pkg::t_status status;

    assign o_in_ready = !busy && !o_out_valid;
    assign o_cfg_ready = 1'b1;
    assign acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cooldown <= '0;
            r_active <= 4'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bac_pkg::CFG_COOLDOWN: r_cooldown <= i_cfg_data;
                bac_pkg::CFG_ACTIVE: r_active <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    bac_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(acc && i_in.func == bac_pkg::FUNC_STEP),
        .i_active(r_active), .i_status(status), .i_out_ready(i_out_ready),
        .o_cmd(cmd), .o_busy(busy), .o_out_valid(o_out_valid), .o_out(o_out)
    );

    bac_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr(acc && i_in.func == bac_pkg::FUNC_WRITE),
        .i_item(i_in), .i_cooldown(r_cooldown), .i_cmd(cmd), .o_status(status)
    );
endmodule
`default_nettype wire
